[sv/casm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// casm_pkg
// Shared constants, codes and types of the set-associative cache hit/miss
// model: parameter defaults, register indexes, policy codes and the
// configuration and way-select structs.
// ----------------------------------------------------------------------------
package casm_pkg;

    // parameter defaults
    localparam int CASM_WAYS_DEF           = 8;
    localparam int CASM_INDEX_BITS_MAX_DEF = 10;

    // address width of the modeled machine; higher address bits read as zero
    localparam int CASM_ADDR_WIDTH = 32;
    localparam logic [31:0] CASM_ADDR_MASK = (CASM_ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
        32'((64'd1 << CASM_ADDR_WIDTH) - 64'd1);

    // stream payload widths (fields packed, padded to whole bytes)
    localparam int CASM_S_TDATA_W = 40;   // address, random_way
    localparam int CASM_M_TDATA_W = 112;  // set, tag, way, hits, misses

    // configuration port
    localparam int CASM_CFG_IDX_W  = 3;
    localparam int CASM_CFG_DATA_W = 5;

    typedef enum logic [CASM_CFG_IDX_W-1:0] {
        CFG_REPLACE_POLICY = 3'd0,
        CFG_WRITE_THROUGH  = 3'd1,
        CFG_OFFSET_BITS    = 3'd2,
        CFG_INDEX_BITS     = 3'd3,
        CFG_WAYS_IN_USE    = 3'd4
    } casm_cfg_idx_t;

    // replacement policy codes; the unused code behaves as lru
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_RANDOM = 2'd1;
    localparam logic [1:0] POL_LRU    = 2'd2;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // register reset values
    localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd4;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

    typedef struct packed {
        logic [1:0] replace_policy;
        logic       write_through;
        logic [4:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways_in_use;
    } casm_cfg_t;

    // lookup outcome handed from the way selector to the control
    typedef struct packed {
        logic hit;
        logic fill;
        logic lru;
        logic fifo;
    } casm_sel_t;

endpackage
`default_nettype wire

[sv/casm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// casm_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module casm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[sv/casm_way_select.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// casm_way_select
// Tag match over the ways in use of one set row, lowest free way search,
// least-order victim tree (fifo counts or lru stamps) and random clamp.
// ----------------------------------------------------------------------------
module casm_way_select #(
    parameter int WAYS  = 8,
    parameter int WAY_W = 3
) (
    input  wire casm_pkg::casm_cfg_t    cfg,
    input  wire logic                   is_write,
    input  wire logic [2:0]             rnd_way,
    input  wire logic [31:0]            tag,
    input  wire logic [WAYS-1:0][31:0]  tag_row,
    input  wire logic [WAYS-1:0]        valid_row,
    input  wire logic [WAYS-1:0][31:0]  order_row,
    output casm_pkg::casm_sel_t         sel,
    output logic      [WAY_W-1:0]       way
);
    import casm_pkg::*;

    localparam int NW_W = $clog2(WAYS + 1) > 5 ? $clog2(WAYS + 1) : 5;
    localparam int PW   = 2 ** $clog2(WAYS);

    logic [NW_W-1:0]   nways;
    logic [WAYS-1:0]   in_use;
    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   free;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  rnd_c;
    logic [WAY_W-1:0]  min_way;
    logic              any_hit;
    logic              any_free;
    logic              fill;
    logic              lru;
    logic              fifo;

    logic              node_ok  [1:2*PW-1];
    logic [31:0]       node_val [1:2*PW-1];
    logic [WAY_W-1:0]  node_idx [1:2*PW-1];

    // effective associativity: zero acts as one, above WAYS acts as WAYS
    always_comb begin
        if (cfg.ways_in_use == 4'd0) begin
            nways = NW_W'(1);
        end else if (NW_W'(cfg.ways_in_use) > NW_W'(WAYS)) begin
            nways = NW_W'(WAYS);
        end else begin
            nways = NW_W'(cfg.ways_in_use);
        end
    end

    // per-way flags
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            in_use[w] = (NW_W'(w) < nways);
            match[w]  = in_use[w] && valid_row[w] && (tag_row[w] == tag);
            free[w]   = in_use[w] && !valid_row[w];
        end
    end

    // lowest matching way and lowest free way
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    assign any_hit  = |match;
    assign any_free = |free;

    // least order value among the ways in use, lower way wins ties
    always_comb begin
        for (int i = 0; i < PW; i++) begin
            node_ok[PW + i]  = (i < WAYS) && (NW_W'(i) < nways);
            node_val[PW + i] = (i < WAYS) ? order_row[(i < WAYS) ? i : 0] : 32'd0;
            node_idx[PW + i] = WAY_W'(i);
        end
        for (int n = PW - 1; n >= 1; n--) begin
            if (node_ok[2*n+1] && (!node_ok[2*n] || (node_val[2*n+1] < node_val[2*n]))) begin
                node_ok[n]  = node_ok[2*n+1];
                node_val[n] = node_val[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end else begin
                node_ok[n]  = node_ok[2*n];
                node_val[n] = node_val[2*n];
                node_idx[n] = node_idx[2*n];
            end
        end
        min_way = node_idx[1];
    end

    // random victim clamped to the ways in use
    assign rnd_c = (NW_W'(rnd_way) >= nways) ? WAY_W'(nways - NW_W'(1)) : WAY_W'(rnd_way);

    assign lru  = cfg.replace_policy[1];
    assign fifo = (cfg.replace_policy == POL_FIFO);
    assign fill = !any_hit && !((is_write == KIND_WRITE) && cfg.write_through);

    // chosen way
    always_comb begin
        priority if (any_hit) begin
            way = hit_way;
        end else if (!fill) begin
            way = '0;
        end else if (any_free) begin
            way = free_way;
        end else if (lru || fifo) begin
            way = min_way;
        end else begin
            way = rnd_c;
        end
    end

    assign sel.hit  = any_hit;
    assign sel.fill = fill;
    assign sel.lru  = lru;
    assign sel.fifo = fifo;

endmodule
`default_nettype wire

[sv/set_assoc_cache_hit_miss_model_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_model_top
// Set-associative cache hit/miss model: one access in, one lookup result out.
//
// Input channel (s_*): one access per transaction, kind on s_tuser, address
// and random victim way on s_tdata. Result channel (m_*): hit on m_tuser,
// set, tag, way and running hit/miss totals on m_tdata.
// Each access is accepted in the idle state, which reads the set row from the
// tag RAM and the valid/order RAM, and is then held in the evaluate state, which
// matches, picks a victim, writes the row back and loads the output register.
// The write lands before the next read can be issued, so accesses to the same
// set never overlap. A new access is taken only once the last one has left
// the evaluate state, a limit set by this single read-modify-write pass over
// the set row memories. After reset a clearing pass walks the valid/order RAM
// one set a cycle over all 2**INDEX_BITS_MAX sets (1024 by default); no access
// is taken meanwhile, configuration writes are. The tag RAM is not cleared.
// When the receiver stalls, one finished result waits in the output register
// while the next access is still accepted and read; that access then holds in
// its evaluate cycle until the output register frees up.
// Configuration must be written by the user only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module set_assoc_cache_hit_miss_model_top #(
    parameter int WAYS           = casm_pkg::CASM_WAYS_DEF,
    parameter int INDEX_BITS_MAX = casm_pkg::CASM_INDEX_BITS_MAX_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input channel
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [casm_pkg::CASM_S_TDATA_W-1:0]   s_tdata,  // address, random_way
    input  wire logic                                  s_tuser,  // kind
    // result channel
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // set_number, tag_value, way_used, total_hits, total_misses
    output logic      [casm_pkg::CASM_M_TDATA_W-1:0]   m_tdata,
    output logic                                       m_tuser,  // hit
    // configuration write port
    input  wire logic                                  cfg_wr_en,
    input  wire logic [casm_pkg::CASM_CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [casm_pkg::CASM_CFG_DATA_W-1:0]  cfg_wr_data
);
    import casm_pkg::*;

    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W    = (INDEX_BITS_MAX > 0) ? INDEX_BITS_MAX : 1;
    localparam int NUM_SETS = 2 ** INDEX_BITS_MAX;
    localparam int TAG_RW   = WAYS * 32;
    localparam int META_RW  = WAYS * 33;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SET_W-1:0]  clr_cnt_reg;
    casm_cfg_t         cfg_reg;

    // captured access
    logic [SET_W-1:0]  set_reg;
    logic [31:0]       tag_reg;
    logic              kind_reg;
    logic [2:0]        rnd_reg;

    // counters
    logic [31:0]       stamp_reg, stamp_next;
    logic [31:0]       hit_cnt_reg, hit_cnt_next;
    logic [31:0]       miss_cnt_reg, miss_cnt_next;

    // output register
    logic              m_valid_reg;
    logic              out_hit_reg;
    logic [9:0]        out_set_reg;
    logic [31:0]       out_tag_reg;
    logic [2:0]        out_way_reg;
    logic [31:0]       out_hits_reg;
    logic [31:0]       out_misses_reg;

    // address split
    logic [31:0]       addr;
    logic [4:0]        ib_c;
    logic [5:0]        shift;
    logic [31:0]       set32;
    logic [31:0]       tag_in;
    logic              accept;
    logic              eval_go;

    // memory ports
    logic [TAG_RW-1:0]      tag_rdata;
    logic [TAG_RW-1:0]      tag_wdata;
    logic                   tag_we;
    logic [META_RW-1:0]     meta_rdata;
    logic [META_RW-1:0]     meta_wdata;
    logic                   meta_we;
    logic [SET_W-1:0]       meta_waddr;

    logic [WAYS-1:0][31:0]  tag_row;
    logic [WAYS-1:0][31:0]  order_row;
    logic [WAYS-1:0]        valid_row;
    logic [WAYS-1:0][31:0]  tag_row_next;
    logic [WAYS-1:0][31:0]  order_row_next;
    logic [WAYS-1:0]        valid_row_next;

    casm_sel_t              sel;
    logic [WAY_W-1:0]       sel_way;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign eval_go  = (state_reg == ST_EVAL) && (!m_valid_reg || m_tready);

    // set index and tag from the incoming address
    always_comb begin
        addr   = s_tdata[31:0] & CASM_ADDR_MASK;
        ib_c   = (5'(cfg_reg.index_bits) > 5'(INDEX_BITS_MAX)) ? 5'(INDEX_BITS_MAX) :
                 5'(cfg_reg.index_bits);
        shift  = 6'(cfg_reg.offset_bits) + 6'(ib_c);
        set32  = (addr >> cfg_reg.offset_bits) & ~(32'hFFFF_FFFF << ib_c);
        tag_in = addr >> shift;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.replace_policy <= POL_FIFO;
            cfg_reg.write_through  <= 1'b0;
            cfg_reg.offset_bits    <= OFFSET_BITS_RST;
            cfg_reg.index_bits     <= INDEX_BITS_RST;
            cfg_reg.ways_in_use    <= WAYS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_REPLACE_POLICY: cfg_reg.replace_policy <= cfg_wr_data[1:0];
                CFG_WRITE_THROUGH:  cfg_reg.write_through  <= cfg_wr_data[0];
                CFG_OFFSET_BITS:    cfg_reg.offset_bits    <= cfg_wr_data[4:0];
                CFG_INDEX_BITS:     cfg_reg.index_bits     <= cfg_wr_data[3:0];
                CFG_WAYS_IN_USE:    cfg_reg.ways_in_use    <= cfg_wr_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (eval_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
        end
    end

    // capture the access at accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg  <= set32[SET_W-1:0];
            tag_reg  <= tag_in;
            kind_reg <= s_tuser;
            rnd_reg  <= s_tdata[34:32];
        end
    end

    // set row memories
    casm_ram #(
        .WIDTH  (TAG_RW),
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_W)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (set_reg),
        .wdata (tag_wdata),
        .re    (accept),
        .raddr (set32[SET_W-1:0]),
        .rdata (tag_rdata)
    );

    casm_ram #(
        .WIDTH  (META_RW),
        .DEPTH  (NUM_SETS),
        .ADDR_W (SET_W)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (set32[SET_W-1:0]),
        .rdata (meta_rdata)
    );

    assign tag_row              = tag_rdata;
    assign {order_row, valid_row} = meta_rdata;

    // hit detection and victim choice
    casm_way_select #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_way_select (
        .cfg       (cfg_reg),
        .is_write  (kind_reg),
        .rnd_way   (rnd_reg),
        .tag       (tag_reg),
        .tag_row   (tag_row),
        .valid_row (valid_row),
        .order_row (order_row),
        .sel       (sel),
        .way       (sel_way)
    );

    // row update and counters
    always_comb begin
        tag_row_next   = tag_row;
        order_row_next = order_row;
        valid_row_next = valid_row;
        stamp_next     = stamp_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        if (sel.hit) begin
            hit_cnt_next = hit_cnt_reg + 32'd1;
            if (sel.lru) begin
                order_row_next[sel_way] = stamp_reg;
                stamp_next              = stamp_reg + 32'd1;
            end
        end else begin
            miss_cnt_next = miss_cnt_reg + 32'd1;
            if (sel.fill) begin
                tag_row_next[sel_way]   = tag_reg;
                valid_row_next[sel_way] = 1'b1;
                if (sel.lru) begin
                    order_row_next[sel_way] = stamp_reg;
                    stamp_next              = stamp_reg + 32'd1;
                end else if (sel.fifo) begin
                    order_row_next[sel_way] = order_row[sel_way] + 32'd1;
                end
            end
        end
    end

    // write back, or zero the valid/order rows during the clearing pass
    always_comb begin
        tag_we    = eval_go && sel.fill;
        tag_wdata = tag_row_next;
        if (state_reg == ST_CLEAR) begin
            meta_we    = 1'b1;
            meta_waddr = clr_cnt_reg;
            meta_wdata = '0;
        end else begin
            meta_we    = eval_go && (sel.fill || (sel.hit && sel.lru));
            meta_waddr = set_reg;
            meta_wdata = {order_row_next, valid_row_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg    <= 32'd1;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else if (eval_go) begin
            stamp_reg    <= stamp_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eval_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_go) begin
            out_hit_reg    <= sel.hit;
            out_set_reg    <= 10'(set_reg);
            out_tag_reg    <= tag_reg;
            out_way_reg    <= 3'(sel_way);
            out_hits_reg   <= hit_cnt_next;
            out_misses_reg <= miss_cnt_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {3'd0, out_misses_reg, out_hits_reg, out_way_reg, out_tag_reg,
                       out_set_reg};

    // an accepted access enters the evaluate state in the following cycle
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted access not followed by evaluate");

    // every evaluated access leaves a result in the output register
    a_eval_out: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_go |=> m_valid_reg)
        else $error("evaluated access produced no result");

    // each result counts exactly one hit or one miss
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_go |=> (32'(hit_cnt_reg + miss_cnt_reg) ==
                     32'($past(hit_cnt_reg) + $past(miss_cnt_reg) + 32'd1)))
        else $error("hit and miss totals did not advance by one");

    // a hit never allocates
    a_hit_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (eval_go && sel.hit) |-> !sel.fill)
        else $error("hit flagged as fill");

    // no access is taken while the metadata is being cleared
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        meta_we && (state_reg == ST_CLEAR) |-> !accept && !tag_we)
        else $error("access overlapped the clearing pass");

endmodule
`default_nettype wire
